// File: sv/page_frame_allocator_with_stats_assert.svh
// assertion macros for the page frame allocator
`ifndef PAGE_FRAME_ALLOCATOR_WITH_STATS_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_WITH_STATS_ASSERT_SVH
`ifndef SYNTHESIS
`define PFA_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pfa assertion failed");
`define PFA_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pfa assertion failed");
`else
`define PFA_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define PFA_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

// File: sv/pfa_pkg.sv
// shared codes and widths of the page frame allocator
package pfa_pkg;

    localparam int FUNC_W   = 2;
    localparam int BYTES_W  = 31;
    localparam int FRAME_W  = 8;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 32;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int SHIFT_W  = 5;

    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_ACCESS  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOROOM = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 1'd1;

    localparam logic [FRAME_W-1:0] MAX_FRAME_RST  = 8'd255;
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd12;

endpackage

// File: sv/pfa_ram.sv
// single port write, single port read memory with registered read data
module pfa_ram #(
    parameter int DATA_W = 9,
    parameter int ADDR_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/page_frame_allocator_with_stats.sv
// top level of the page frame allocator with per-frame access counters
//
// a transaction is taken when start is high and busy is low; each answered
// transaction gives one result on the done strobe for a single cycle, and the
// receiver cannot stall it. after reset the block runs a clearing pass over
// every frame of both memories with busy high (configuration writes are
// still taken). busy drops in the result cycle, so the next transaction can
// be taken at the edge that takes the result. an error found up front is
// answered straight from idle; access does a read-modify-write of the
// counter memory, and a release or access of a frame found not in use is
// answered after the memory read; release frees the chain one frame per
// step and ends when the walk reads a frame not in use or a link it cannot
// follow; allocate takes never-used frames directly and pops frames off the
// free list through a link memory read, then ends the chain. func code 3 is
// dropped.
module page_frame_allocator_with_stats #(
    parameter int NUM_FRAMES  = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pfa_pkg::FUNC_W-1:0]    func,
    input  logic [pfa_pkg::BYTES_W-1:0]   byte_count,
    input  logic [pfa_pkg::FRAME_W-1:0]   frame,
    input  logic                          is_write,
    output logic                          done,
    output logic [pfa_pkg::FUNC_W-1:0]    done_func,
    output logic [pfa_pkg::FRAME_W-1:0]   result_frame,
    output logic [pfa_pkg::STATUS_W-1:0]  status,
    output logic [pfa_pkg::FRAME_W-1:0]   pages_granted,
    output logic [pfa_pkg::TOTAL_W-1:0]   read_total,
    output logic [pfa_pkg::TOTAL_W-1:0]   write_total,
    output logic [pfa_pkg::TOTAL_W-1:0]   access_total,
    input  logic                          cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfa_pkg::CFG_W-1:0]     cfg_data
);

    import pfa_pkg::*;

    `include "page_frame_allocator_with_stats_assert.svh"

    // frame index, count and limit arithmetic widths
    localparam int FW = (NUM_FRAMES > 2) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = FW + 1;
    localparam int LW = ((FW > FRAME_W) ? FW : FRAME_W) + 2;
    localparam int LKW = FW + 1;
    localparam int SW = 3 * COUNT_WIDTH;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_ALLOC_POP,
        S_ALLOC_END,
        S_REL_WALK,
        S_ACC_WR
    } state_t;

    // configuration registers
    logic [FRAME_W-1:0] max_frame_reg;
    logic [SHIFT_W-1:0] page_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg  <= MAX_FRAME_RST;
            page_shift_reg <= PAGE_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_FRAME:  max_frame_reg  <= cfg_data;
                CFG_PAGE_SHIFT: page_shift_reg <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // control and bookkeeping
    state_t state_reg, state_next;
    logic [FW-1:0] clr_reg, clr_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [FW-1:0] frame_reg, frame_next;
    logic is_write_reg, is_write_next;
    logic [CW-1:0] pages_reg, pages_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [FW-1:0] prev_reg, prev_next;
    logic [FW-1:0] head_reg, head_next;
    logic [FW-1:0] cur_reg, cur_next;
    logic [FW-1:0] free_head_reg, free_head_next;
    logic [CW-1:0] fresh_next_reg, fresh_next_next;
    logic [CW-1:0] used_reg, used_next;

    // registered result
    logic done_reg, done_next;
    logic [FUNC_W-1:0] done_func_reg, done_func_next;
    logic [FRAME_W-1:0] result_frame_reg, result_frame_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [FRAME_W-1:0] pages_granted_reg, pages_granted_next;
    logic [TOTAL_W-1:0] read_total_reg, read_total_next;
    logic [TOTAL_W-1:0] write_total_reg, write_total_next;
    logic [TOTAL_W-1:0] access_total_reg, access_total_next;

    // link memory: {in use, next link}; counter memory: {accesses, writes, reads}
    logic           lnk_we;
    logic [FW-1:0]  lnk_waddr;
    logic [LKW-1:0] lnk_wdata;
    logic [FW-1:0]  lnk_raddr;
    logic [LKW-1:0] lnk_rdata;
    logic           cnt_we;
    logic [FW-1:0]  cnt_waddr;
    logic [SW-1:0]  cnt_wdata;
    logic [FW-1:0]  cnt_raddr;
    logic [SW-1:0]  cnt_rdata;

    pfa_ram #(
        .DATA_W (LKW),
        .ADDR_W (FW),
        .DEPTH  (NUM_FRAMES)
    ) u_link_ram (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .raddr (lnk_raddr),
        .rdata (lnk_rdata)
    );

    pfa_ram #(
        .DATA_W (SW),
        .ADDR_W (FW),
        .DEPTH  (NUM_FRAMES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    logic          rd_use;
    logic [FW-1:0] rd_link;
    assign rd_use  = lnk_rdata[FW];
    assign rd_link = lnk_rdata[FW-1:0];

    // allocate sizing: pages = ceil(bytes / 2^page_shift) against room left
    logic [BYTES_W-1:0] shift_mask;
    logic [BYTES_W-1:0] pages_calc;
    logic [LW-1:0] lim_w, fresh_w, used_w, free_cnt, fresh_cnt, avail;

    always_comb
    begin
        shift_mask = BYTES_W'((32'(1) << page_shift_reg) - 32'(1));
        pages_calc = (byte_count >> page_shift_reg)
                   + BYTES_W'(|(byte_count & shift_mask));
        lim_w   = (LW'(max_frame_reg) < LW'(NUM_FRAMES - 1)) ? LW'(max_frame_reg)
                                                             : LW'(NUM_FRAMES - 1);
        fresh_w = LW'(fresh_next_reg);
        used_w  = LW'(used_reg);
        free_cnt  = (fresh_w - LW'(1) >= used_w) ? fresh_w - LW'(1) - used_w : '0;
        fresh_cnt = (fresh_w <= lim_w) ? lim_w - fresh_w + LW'(1) : '0;
        avail     = free_cnt + fresh_cnt;
    end

    // access counter update
    logic [COUNT_WIDTH-1:0] rd_cnt, wr_cnt, ac_cnt;
    logic [COUNT_WIDTH-1:0] rd_new, wr_new, ac_new;
    logic [63:0] rd_ext, wr_ext, ac_ext;

    always_comb
    begin
        rd_cnt = cnt_rdata[COUNT_WIDTH-1:0];
        wr_cnt = cnt_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
        ac_cnt = cnt_rdata[SW-1:2*COUNT_WIDTH];
        rd_new = rd_cnt;
        wr_new = wr_cnt;
        if (is_write_reg)
        begin
            wr_new = (wr_cnt == '1) ? wr_cnt : wr_cnt + COUNT_WIDTH'(1);
        end
        else
        begin
            rd_new = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);
        end
        ac_new = (ac_cnt == '1) ? ac_cnt : ac_cnt + COUNT_WIDTH'(1);
        rd_ext = 64'(rd_new);
        wr_ext = 64'(wr_new);
        ac_ext = 64'(ac_new);
    end

    logic          take;
    logic [FW-1:0] take_f;
    logic          rel_live;
    logic          rel_go_on;
    logic [CW-1:0] rel_n;

    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        func_next         = func_reg;
        frame_next        = frame_reg;
        is_write_next     = is_write_reg;
        pages_next        = pages_reg;
        cnt_next          = cnt_reg;
        prev_next         = prev_reg;
        head_next         = head_reg;
        cur_next          = cur_reg;
        free_head_next    = free_head_reg;
        fresh_next_next   = fresh_next_reg;
        used_next         = used_reg;
        done_next         = 1'b0;
        done_func_next    = done_func_reg;
        result_frame_next = result_frame_reg;
        status_next       = status_reg;
        pages_granted_next = pages_granted_reg;
        read_total_next   = read_total_reg;
        write_total_next  = write_total_reg;
        access_total_next = access_total_reg;
        lnk_we    = 1'b0;
        lnk_waddr = '0;
        lnk_wdata = '0;
        lnk_raddr = '0;
        cnt_we    = 1'b0;
        cnt_waddr = '0;
        cnt_wdata = '0;
        cnt_raddr = '0;
        take      = 1'b0;
        take_f    = '0;
        rel_live  = 1'b0;
        rel_go_on = 1'b0;
        rel_n     = '0;

        case (state_reg)
            S_CLEAR:
            begin
                lnk_we    = 1'b1;
                lnk_waddr = clr_reg;
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                clr_next  = clr_reg + FW'(1);
                if (clr_reg == FW'(NUM_FRAMES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    func_next     = func;
                    frame_next    = FW'(frame);
                    is_write_next = is_write;
                    cur_next      = FW'(frame);
                    // error results go out with frame, pages and totals all zero
                    done_func_next     = func;
                    result_frame_next  = '0;
                    pages_granted_next = '0;
                    read_total_next    = '0;
                    write_total_next   = '0;
                    access_total_next  = '0;
                    case (func)
                        FN_ALLOC:
                        begin
                            if (byte_count == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_ZERO;
                            end
                            else if (32'(pages_calc) > 32'(avail))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOROOM;
                            end
                            else
                            begin
                                pages_next = CW'(pages_calc);
                                cnt_next   = '0;
                                state_next = S_ALLOC;
                            end
                        end
                        FN_RELEASE, FN_ACCESS:
                        begin
                            if (frame == '0 || 32'(frame) >= NUM_FRAMES)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD;
                            end
                            else
                            begin
                                lnk_raddr  = FW'(frame);
                                cnt_raddr  = FW'(frame);
                                cnt_next   = '0;
                                state_next = (func == FN_RELEASE) ? S_REL_WALK : S_ACC_WR;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_ALLOC:
            begin
                if (free_head_reg != '0)
                begin
                    lnk_raddr  = free_head_reg;
                    state_next = S_ALLOC_POP;
                end
                else
                begin
                    take            = 1'b1;
                    take_f          = fresh_next_reg[FW-1:0];
                    fresh_next_next = fresh_next_reg + CW'(1);
                end
            end

            S_ALLOC_POP:
            begin
                take           = 1'b1;
                take_f         = free_head_reg;
                free_head_next = rd_link;
            end

            S_ALLOC_END:
            begin
                // last frame of the chain ends it
                lnk_we    = 1'b1;
                lnk_waddr = prev_reg;
                lnk_wdata = {1'b1, FW'(0)};
                used_next = used_reg + pages_reg;
                done_next = 1'b1;
                status_next        = ST_OK;
                result_frame_next  = FRAME_W'(head_reg);
                pages_granted_next = FRAME_W'(pages_reg);
                state_next = S_IDLE;
            end

            S_REL_WALK:
            begin
                // a self link would read stale data, stop on it
                rel_live  = rd_use;
                rel_go_on = (rd_link != '0) && (32'(rd_link) < NUM_FRAMES)
                         && (rd_link != cur_reg) && (32'(cnt_reg) + 1 < NUM_FRAMES);
                if (!rel_live && cnt_reg == '0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_BAD;
                    state_next  = S_IDLE;
                end
                else if (!rel_live)
                begin
                    // previous frame was the last live one
                    lnk_we    = 1'b1;
                    lnk_waddr = prev_reg;
                    lnk_wdata = {1'b0, free_head_reg};
                    rel_n     = cnt_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = cur_reg;
                    lnk_we    = 1'b1;
                    lnk_waddr = cur_reg;
                    prev_next = cur_reg;
                    cnt_next  = cnt_reg + CW'(1);
                    if (rel_go_on)
                    begin
                        lnk_wdata = {1'b0, rd_link};
                        lnk_raddr = rd_link;
                        cur_next  = rd_link;
                    end
                    else
                    begin
                        lnk_wdata  = {1'b0, free_head_reg};
                        rel_n      = cnt_reg + CW'(1);
                        state_next = S_IDLE;
                    end
                end
                if (state_next == S_IDLE && rel_live)
                begin
                    done_next = 1'b1;
                end
                if (state_next == S_IDLE && (rel_live || cnt_reg != '0))
                begin
                    done_next         = 1'b1;
                    status_next       = ST_OK;
                    result_frame_next = FRAME_W'(frame_reg);
                    free_head_next    = frame_reg;
                    used_next = (used_reg >= rel_n) ? used_reg - rel_n : '0;
                end
            end

            S_ACC_WR:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (!rd_use)
                begin
                    status_next = ST_BAD;
                end
                else
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = frame_reg;
                    cnt_wdata = {ac_new, wr_new, rd_new};
                    status_next       = ST_OK;
                    result_frame_next = FRAME_W'(frame_reg);
                    read_total_next   = rd_ext[TOTAL_W-1:0];
                    write_total_next  = wr_ext[TOTAL_W-1:0];
                    access_total_next = ac_ext[TOTAL_W-1:0];
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // chain one more frame onto the allocation
        if (take)
        begin
            if (cnt_reg == '0)
            begin
                head_next = take_f;
            end
            else
            begin
                lnk_we    = 1'b1;
                lnk_waddr = prev_reg;
                lnk_wdata = {1'b1, take_f};
            end
            prev_next  = take_f;
            cnt_next   = cnt_reg + CW'(1);
            state_next = (cnt_reg + CW'(1) == pages_reg) ? S_ALLOC_END : S_ALLOC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            free_head_reg  <= '0;
            fresh_next_reg <= CW'(1);
            used_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            free_head_reg  <= free_head_next;
            fresh_next_reg <= fresh_next_next;
            used_reg       <= used_next;
            done_reg       <= done_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge clk)
    begin
        func_reg          <= func_next;
        frame_reg         <= frame_next;
        is_write_reg      <= is_write_next;
        pages_reg         <= pages_next;
        cnt_reg           <= cnt_next;
        prev_reg          <= prev_next;
        head_reg          <= head_next;
        cur_reg           <= cur_next;
        done_func_reg     <= done_func_next;
        result_frame_reg  <= result_frame_next;
        status_reg        <= status_next;
        pages_granted_reg <= pages_granted_next;
        read_total_reg    <= read_total_next;
        write_total_reg   <= write_total_next;
        access_total_reg  <= access_total_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign done_func     = done_func_reg;
    assign result_frame  = result_frame_reg;
    assign status        = status_reg;
    assign pages_granted = pages_granted_reg;
    assign read_total    = read_total_reg;
    assign write_total   = write_total_reg;
    assign access_total  = access_total_reg;

    // a result is only shown once the sequencer is back at rest
    `PFA_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    // a failed transaction hands out no frames
    `PFA_ASSERT_IMP(a_err_zero, clk, rst_n, done && status != ST_OK,
                    result_frame == '0 && pages_granted == '0)
    // frames in use never exceed frames created
    `PFA_ASSERT_IMP(a_used_bound, clk, rst_n, !busy, used_reg < fresh_next_reg)
    // a checked transaction makes the block busy in the next cycle, unless it is refused as a bad frame
    `PFA_ASSERT_NXT(a_start_busy, clk, rst_n,
                    start && !busy && (func == FN_RELEASE || func == FN_ACCESS)
                    && frame != '0, busy || (done && status == ST_BAD))

endmodule
